// ===== hw/rtl/mbp_pkg.sv =====
// Shared types, constants and pattern tables of the beep pattern player.
package mbp_pkg;

  localparam int CountWidthDef = 16;
  localparam int DurWidth      = 16;
  localparam int NumPatterns   = 6;
  localparam int MaxPhases     = 17;
  localparam int SoundWidth    = 3;
  localparam int StepWidth     = 5;

  localparam logic [DurWidth-1:0] DitReset  = 16'd100;
  localparam logic [DurWidth-1:0] DahReset  = 16'd300;
  localparam logic [DurWidth-1:0] EgapReset = 16'd100;
  localparam logic [DurWidth-1:0] LgapReset = 16'd300;

  typedef enum logic [1:0] {
    PH_DIT  = 2'd0,
    PH_DAH  = 2'd1,
    PH_EGAP = 2'd2,
    PH_LGAP = 2'd3
  } phase_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_DIT  = 2'd0,
    CFG_DAH  = 2'd1,
    CFG_EGAP = 2'd2,
    CFG_LGAP = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    op_e                   op;
    logic [SoundWidth-1:0] sound;
  } in_item_t;

  typedef struct packed {
    logic buzzer_on;
    logic busy_res;
    logic done_res;
    logic start_rejected;
  } out_item_t;

  typedef struct packed {
    logic [DurWidth-1:0] dit_ticks;
    logic [DurWidth-1:0] dah_ticks;
    logic [DurWidth-1:0] element_gap_ticks;
    logic [DurWidth-1:0] letter_gap_ticks;
  } cfg_t;

  // Unused slots read as an element gap.
  localparam phase_e PatRom [NumPatterns][MaxPhases] = '{
    '{PH_DIT, PH_EGAP, PH_DIT, PH_EGAP, PH_DAH, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP,
      PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP},
    '{PH_DIT, PH_EGAP, PH_DIT, PH_EGAP, PH_DIT, PH_EGAP, PH_DIT, PH_EGAP, PH_DIT,
      PH_EGAP, PH_DAH, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP},
    '{PH_DIT, PH_EGAP, PH_DAH, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP,
      PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP},
    '{PH_DIT, PH_EGAP, PH_DIT, PH_EGAP, PH_DIT, PH_LGAP, PH_DAH, PH_EGAP, PH_DAH,
      PH_EGAP, PH_DAH, PH_LGAP, PH_DIT, PH_EGAP, PH_DIT, PH_EGAP, PH_DIT},
    '{PH_DIT, PH_EGAP, PH_DIT, PH_EGAP, PH_DIT, PH_LGAP, PH_DAH, PH_EGAP, PH_DAH,
      PH_LGAP, PH_DIT, PH_EGAP, PH_DIT, PH_EGAP, PH_DIT, PH_EGAP, PH_EGAP},
    '{PH_DAH, PH_EGAP, PH_DAH, PH_EGAP, PH_DAH, PH_LGAP, PH_DAH, PH_EGAP, PH_DIT,
      PH_EGAP, PH_DAH, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP, PH_EGAP}
  };

  localparam logic [StepWidth-1:0] PatLen [NumPatterns] = '{
    5'd5, 5'd11, 5'd3, 5'd17, 5'd15, 5'd11
  };

  function automatic phase_e phase_code(input logic [SoundWidth-1:0] pat,
                                        input logic [StepWidth-1:0]  idx);
    phase_e code;
    code = PH_EGAP;
    if ((32'(pat) < NumPatterns) && (32'(idx) < MaxPhases)) begin
      code = PatRom[pat][idx];
    end
    return code;
  endfunction

  function automatic logic [StepWidth-1:0] pat_len(input logic [SoundWidth-1:0] pat);
    logic [StepWidth-1:0] len;
    len = '0;
    if (32'(pat) < NumPatterns) begin
      len = PatLen[pat];
    end
    return len;
  endfunction

endpackage

// ===== hw/rtl/mbp_cfg_regs.sv =====
// Duration configuration registers of the beep pattern player.
module mbp_cfg_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [mbp_pkg::DurWidth-1:0] cfg_data_i,
  output mbp_pkg::cfg_t           cfg_o
);
  import mbp_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_DIT:  cfg_d.dit_ticks         = cfg_data_i;
        CFG_DAH:  cfg_d.dah_ticks         = cfg_data_i;
        CFG_EGAP: cfg_d.element_gap_ticks = cfg_data_i;
        CFG_LGAP: cfg_d.letter_gap_ticks  = cfg_data_i;
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dit_ticks         <= DitReset;
      cfg_q.dah_ticks         <= DahReset;
      cfg_q.element_gap_ticks <= EgapReset;
      cfg_q.letter_gap_ticks  <= LgapReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/mbp_sequencer.sv =====
// Pattern sequencer: phase counter, step index and the next-state logic per item.
module mbp_sequencer #(
  parameter int COUNT_WIDTH = mbp_pkg::CountWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  mbp_pkg::in_item_t   item_i,
  input  mbp_pkg::cfg_t       cfg_i,
  output mbp_pkg::out_item_t  result_o
);
  import mbp_pkg::*;

  localparam int ExtW = (COUNT_WIDTH > DurWidth) ? COUNT_WIDTH : DurWidth;

  logic [SoundWidth-1:0]  pat_q, pat_d;
  logic [StepWidth-1:0]   step_q, step_d;
  logic [COUNT_WIDTH-1:0] ticks_q, ticks_d;
  logic                   run_q, run_d;

  logic                   is_start;
  logic [StepWidth-1:0]   step_next;
  logic [COUNT_WIDTH-1:0] ticks_dec;
  phase_e                 load_code;
  phase_e                 out_code;
  logic [DurWidth-1:0]    raw_len;
  logic [ExtW-1:0]        len_ext;
  logic [ExtW-1:0]        cnt_max_ext;
  logic [COUNT_WIDTH-1:0] phase_len;
  logic                   done;
  logic                   rejected;

  assign is_start  = (item_i.op == OP_START);
  assign step_next = step_q + StepWidth'(1);
  assign ticks_dec = (ticks_q != '0) ? (ticks_q - COUNT_WIDTH'(1)) : ticks_q;

  // One length lookup serves both a start and a phase advance.
  assign load_code = is_start ? phase_code(item_i.sound, '0) : phase_code(pat_q, step_next);

  always_comb begin
    case (load_code)
      PH_DIT:  raw_len = cfg_i.dit_ticks;
      PH_DAH:  raw_len = cfg_i.dah_ticks;
      PH_EGAP: raw_len = cfg_i.element_gap_ticks;
      default: raw_len = cfg_i.letter_gap_ticks;
    endcase
  end

  // Zero counts as one tick; saturate when the counter is narrower than the register.
  always_comb begin
    cnt_max_ext = ExtW'({COUNT_WIDTH{1'b1}});
    len_ext     = ExtW'(raw_len);
    if (len_ext == '0) begin
      len_ext = ExtW'(1);
    end
    if (len_ext > cnt_max_ext) begin
      len_ext = cnt_max_ext;
    end
    phase_len = len_ext[COUNT_WIDTH-1:0];
  end

  always_comb begin
    pat_d    = pat_q;
    step_d   = step_q;
    ticks_d  = ticks_q;
    run_d    = run_q;
    done     = 1'b0;
    rejected = 1'b0;
    if (accept_i) begin
      if (is_start) begin
        if (run_q || (32'(item_i.sound) >= NumPatterns)) begin
          rejected = 1'b1;
        end else begin
          pat_d   = item_i.sound;
          step_d  = '0;
          run_d   = 1'b1;
          ticks_d = phase_len;
        end
      end else if (run_q) begin
        ticks_d = ticks_dec;
        if (ticks_dec == '0) begin
          if (step_next >= pat_len(pat_q)) begin
            run_d  = 1'b0;
            step_d = '0;
            done   = 1'b1;
          end else begin
            step_d  = step_next;
            ticks_d = phase_len;
          end
        end
      end
    end
  end

  assign out_code = phase_code(pat_d, step_d);

  always_comb begin
    result_o.buzzer_on      = run_d && ((out_code == PH_DIT) || (out_code == PH_DAH));
    result_o.busy_res       = run_d;
    result_o.done_res       = done;
    result_o.start_rejected = rejected;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q   <= '0;
      step_q  <= '0;
      ticks_q <= '0;
      run_q   <= 1'b0;
    end else begin
      pat_q   <= pat_d;
      step_q  <= step_d;
      ticks_q <= ticks_d;
      run_q   <= run_d;
    end
  end

endmodule

// ===== hw/rtl/morse_beep_pattern_player_core.sv =====
// Plays one of six fixed beep patterns, stepped by tick items, one result per item.
// Each accepted item (a tick or a start) updates the phase counter and step index in
// the cycle it is taken and its result appears in the output register on the next
// cycle, so the block takes one item per clock. The output register is the only stage
// between the channels: a new item is taken whenever that register is empty or its
// result is being taken in the same cycle. Durations come from four 16-bit registers
// (dit, dah, element gap, letter gap) written through the configuration port; a zero
// duration plays as one tick, and with COUNT_WIDTH below 16 a duration saturates.
module morse_beep_pattern_player_core #(
  parameter int COUNT_WIDTH = mbp_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mbp_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mbp_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [mbp_pkg::DurWidth-1:0]  cfg_data_i
);
  import mbp_pkg::*;

  cfg_t      cfg;
  out_item_t result;
  out_item_t out_item_q;
  logic      out_valid_q, out_valid_d;
  logic      accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  mbp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mbp_sequencer #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Hold the result until taken; refill on the cycle it leaves.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
